/* hdl/trial_division_prime_test_top_assert.svh */
// ----------------------------------------------------------------------------
// trial division prime test assertion macros
// shared property forms for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_ASSERT_SVH

// condition holds at every edge out of reset
`define TDPT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define TDPT_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in one cycle implies consequent in the next cycle
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/tdpt_pkg.sv */
// ----------------------------------------------------------------------------
// tdpt_pkg
// types and fixed constants of the trial division prime test
// ----------------------------------------------------------------------------
package tdpt_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 16;
    localparam int CAND_W     = 17;

    // remainder unit: radix-2 restoring steps, several per clock
    localparam int REM_BITS   = 4;
    localparam int REM_CYCLES = DIVIDEND_W / REM_BITS;
    localparam int REM_CNT_W  = $clog2(REM_CYCLES);

    localparam int SEED_COUNT = 6;
    localparam int SEED_IDX_W = $clog2(SEED_COUNT);

    localparam logic [DIVISOR_W-1:0] SEED_PRIMES [SEED_COUNT] = '{
        16'd2, 16'd3, 16'd5, 16'd7, 16'd11, 16'd13
    };

    localparam logic [CAND_W-1:0] CAND_FIRST = 17'd17;
    localparam logic [CAND_W-1:0] CAND_STEP  = 17'd2;

    typedef struct packed {
        logic busy;
        logic done;
        logic zero;
    } rem_status_t;

endpackage

/* hdl/trial_division_prime_test_top.sv */
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// 32-bit primality test by trial division against a self-built prime table
// ----------------------------------------------------------------------------
//  channel | signals                    | direction | transfer when
//  --------+----------------------------+-----------+----------------------------
//  input   | in_valid, in_stall, number | in        | in_valid && !in_stall
//  output  | out_valid, out_stall,      | out       | out_valid && !out_stall
//          | is_prime                   |           |
//
//  after reset the table is built first: six seed primes, then every odd
//  candidate from 17 below PRIME_LIMIT is trial divided; in_stall stays high
//  until that finishes
//  each trial is a table read, a square, a compare and the remainder unit
//  (4 quotient bits per cycle); a 32-bit prime needs at most one trial per
//  table prime, 6542 of them at the default parameters
//  one item is in flight at a time; the result waits in an output register,
//  and a new transfer is taken as soon as the sequencer is back in idle
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_top_assert.svh"

module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int TABLE_DEPTH = 8192,
    parameter int PRIME_LIMIT = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] number,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        is_prime
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0]  DEPTH_C = CNT_W'(TABLE_DEPTH);
    localparam logic [CAND_W-1:0] LIMIT_C = CAND_W'(PRIME_LIMIT);

    typedef enum logic [2:0] {
        S_SEED,      // write the fixed seed primes
        S_NEXT_CAND, // pick the next build candidate or finish the table
        S_IDLE,      // table ready, wait for an input transfer
        S_FETCH,     // table read in flight, end of table check
        S_SQUARE,    // square the fetched prime
        S_CHECK,     // p*p above the value ends the search
        S_DIV,       // remainder unit running
        S_FINISH     // store the prime or hand the verdict out
    } state_t;

    state_t                state_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CAND_W-1:0]     cand_reg;
    logic                  ready_reg;
    logic                  testing_reg;
    logic                  verdict_reg;
    logic [DIVIDEND_W-1:0] dividend_reg;
    logic [DIVIDEND_W-1:0] sq_reg;
    logic                  out_valid_reg;
    logic                  is_prime_reg;

    // prime table, written only at count_reg
    logic [DIVISOR_W-1:0]  table_mem [TABLE_DEPTH];
    logic [DIVISOR_W-1:0]  rd_data_reg;

    logic                  wr_en;
    logic [DIVISOR_W-1:0]  wr_data;
    logic                  rem_start;
    logic                  sq_above;
    logic                  load_result;
    rem_status_t           rem_status;

    // stores happen while seeding and when a build candidate proves prime
    assign wr_en = (state_reg == S_SEED) ||
                   (state_reg == S_FINISH && !testing_reg && verdict_reg &&
                    count_reg < DEPTH_C);
    assign wr_data = (state_reg == S_SEED) ? SEED_PRIMES[count_reg[SEED_IDX_W-1:0]]
                                           : cand_reg[DIVISOR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[count_reg[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= table_mem[idx_reg[ADDR_W-1:0]];
    end

    assign sq_above  = (sq_reg > dividend_reg);
    assign rem_start = (state_reg == S_CHECK) && !sq_above;

    // a finished test moves into the result register once it is free or draining
    assign load_result = (state_reg == S_FINISH) && testing_reg &&
                         (!out_valid_reg || !out_stall);

    tdpt_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (dividend_reg),
        .divisor  (rd_data_reg),
        .status   (rem_status)
    );

    // sequencer: table build first, then one test per input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_SEED;
            count_reg     <= '0;
            idx_reg       <= '0;
            cand_reg      <= CAND_FIRST;
            ready_reg     <= 1'b0;
            testing_reg   <= 1'b0;
            verdict_reg   <= 1'b0;
            dividend_reg  <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
            is_prime_reg  <= 1'b0;
        end
        else
        begin
            // result register fills from a finished test, empties on an output transfer
            if (load_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_SEED:
                begin
                    count_reg <= count_reg + 1'b1;
                    if (count_reg == CNT_W'(SEED_COUNT - 1))
                    begin
                        state_reg <= S_NEXT_CAND;
                    end
                end
                S_NEXT_CAND:
                begin
                    if (cand_reg < LIMIT_C)
                    begin
                        // odd candidates skip the prime two
                        dividend_reg <= DIVIDEND_W'(cand_reg);
                        idx_reg      <= CNT_W'(1);
                        testing_reg  <= 1'b0;
                        state_reg    <= S_FETCH;
                    end
                    else
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        dividend_reg <= number;
                        idx_reg      <= '0;
                        testing_reg  <= 1'b1;
                        state_reg    <= S_FETCH;
                    end
                end
                S_FETCH:
                begin
                    // table exhausted: no divisor found
                    if (idx_reg >= count_reg)
                    begin
                        verdict_reg <= 1'b1;
                        state_reg   <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    sq_reg    <= {16'd0, rd_data_reg} * {16'd0, rd_data_reg};
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    if (sq_above)
                    begin
                        verdict_reg <= 1'b1;
                        state_reg   <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (rem_status.done)
                    begin
                        if (rem_status.zero)
                        begin
                            verdict_reg <= 1'b0;
                            state_reg   <= S_FINISH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_FETCH;
                        end
                    end
                end
                S_FINISH:
                begin
                    if (!testing_reg)
                    begin
                        // a prime found with the table full is dropped
                        if (verdict_reg && count_reg < DEPTH_C)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        cand_reg  <= cand_reg + CAND_STEP;
                        state_reg <= S_NEXT_CAND;
                    end
                    else if (load_result)
                    begin
                        is_prime_reg <= verdict_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_SEED;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign is_prime  = is_prime_reg;

    // checks
    `TDPT_ASSERT_IMPLY(a_input_after_build, in_valid && !in_stall, ready_reg,
        "input transfer taken before the prime table was built")
    `TDPT_ASSERT_IMPLY(a_rem_start_idle, rem_start, !rem_status.busy,
        "remainder unit restarted while busy")
    `TDPT_ASSERT_ALWAYS(a_count_bound, count_reg <= DEPTH_C,
        "prime count beyond table depth")
    `TDPT_ASSERT_NEXT(a_one_result, state_reg == S_FINISH && testing_reg &&
        (!out_valid_reg || !out_stall), out_valid_reg && state_reg == S_IDLE,
        "finished test did not load the result register")

endmodule

/* hdl/tdpt_rem_unit.sv */
// ----------------------------------------------------------------------------
// tdpt_rem_unit
// iterative remainder of a 32-bit dividend by a nonzero 16-bit divisor
// ----------------------------------------------------------------------------
module tdpt_rem_unit
    import tdpt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output rem_status_t           status
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [REM_CNT_W-1:0]  cnt_reg;
    logic [DIVIDEND_W-1:0] dvd_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;

    // REM_BITS restoring steps per clock
    always_comb
    begin
        logic [DIVISOR_W:0]   trial;
        logic [DIVISOR_W-1:0] r;
        r = rem_reg;
        for (int i = 0; i < REM_BITS; i++)
        begin
            trial = {r, dvd_reg[DIVIDEND_W-1-i]};
            if (trial >= {1'b0, dsr_reg})
            begin
                trial = trial - {1'b0, dsr_reg};
            end
            r = trial[DIVISOR_W-1:0];
        end
        rem_next = r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == REM_CNT_W'(REM_CYCLES - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << REM_BITS;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule
